@@ hdl/mice_pkg.sv @@
`default_nettype none
package mice_pkg;

  localparam int unsigned DataWordsDefault = 4096;

  localparam logic [2:0] CMD_EXEC    = 3'd0;
  localparam logic [2:0] CMD_PRELOAD = 3'd1;
  localparam logic [2:0] CMD_WRREG   = 3'd2;
  localparam logic [2:0] CMD_SETPC   = 3'd3;
  localparam logic [2:0] CMD_RDREG   = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_MIS = 2'd2;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_LWR     = 6'd38;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SWL     = 6'd42;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_SWR     = 6'd46;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [4:0] RT_BLTZ   = 5'd0;
  localparam logic [4:0] RT_BGEZ   = 5'd1;
  localparam logic [4:0] RT_BLTZAL = 5'd16;
  localparam logic [4:0] RT_BGEZAL = 5'd17;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic latch;
    logic rd_regs;
    logic agen;
    logic commit;
  } mice_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } mice_sts_t;

endpackage
`default_nettype wire

@@ hdl/mice_ctrl.sv @@
`default_nettype none
module mice_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mice_pkg::mice_sts_t sts_i,
  output mice_pkg::mice_cmd_t     cmd_o
);
  import mice_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REG  = 2'd1;
  localparam logic [1:0] S_AGEN = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done;

  assign in_ready_o = (state_q == S_IDLE);
  assign done = (state_q == S_EXEC) && !sts_i.div_busy && !sts_i.out_busy;

  always_comb begin
    cmd_o.latch   = in_valid_i && in_ready_o;
    cmd_o.rd_regs = (state_q == S_REG);
    cmd_o.agen    = (state_q == S_AGEN);
    cmd_o.commit  = done;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_REG;
      S_REG:  state_d = S_AGEN;
      S_AGEN: state_d = S_EXEC;
      S_EXEC: if (done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

@@ hdl/mice_dpath.sv @@
`default_nettype none
module mice_dpath #(
  parameter int unsigned DataWords = mice_pkg::DataWordsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mice_pkg::mice_cmd_t cmd_i,
  output mice_pkg::mice_sts_t      sts_o,
  input  wire logic [2:0]          command_i,
  input  wire logic [31:0]         instruction_i,
  input  wire logic [31:0]         address_i,
  input  wire logic [4:0]          reg_index_i,
  input  wire logic [31:0]         data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              pc_o,
  output logic [1:0]               status_o,
  output logic                     reg_written_o,
  output logic [4:0]               written_index_o,
  output logic [31:0]              written_value_o,
  output logic [31:0]              read_value_o
);
  import mice_pkg::*;

  localparam int unsigned AW = $clog2(DataWords);

  logic [2:0]  cmd_q;
  logic [31:0] ins_q, addr_q, data_q;
  logic [4:0]  ri_q;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rfa_q, rfb_q;
  logic        va_q, vb_q;
  logic [4:0]  ra;

  logic [31:0] dmem [DataWords];
  logic [31:0] w_q, ea_q;
  logic [63:0] prod_q;

  logic [31:0] pc_q, npc_q, hi_q, lo_q;
  logic        out_valid_q;

  logic [5:0]  div_cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic        qneg_q, rneg_q;
  logic [32:0] div_t;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] imm, simm, a, b, ea_now;
  logic [AW-1:0] slot_now, slot_ea;

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        hi_we, lo_we;
  logic [31:0] hi_wd, lo_wd;
  logic [31:0] after, pc_nx, npc_nx, rv;
  logic [1:0]  st;

  assign op   = ins_q[31:26];
  assign rs   = ins_q[25:21];
  assign rt   = ins_q[20:16];
  assign rd   = ins_q[15:11];
  assign sa   = ins_q[10:6];
  assign fn   = ins_q[5:0];
  assign imm  = {16'h0000, ins_q[15:0]};
  assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
  assign a    = va_q ? rfa_q : 32'h0;
  assign b    = vb_q ? rfb_q : 32'h0;
  assign ra   = (cmd_q == CMD_RDREG) ? ri_q : rs;
  assign ea_now   = a + simm;
  assign slot_now = ea_now[AW+1:2];
  assign slot_ea  = ea_q[AW+1:2];

  assign sts_o.div_busy = (div_cnt_q != 6'd0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= command_i;
      ins_q  <= instruction_i;
      addr_q <= address_i;
      ri_q   <= reg_index_i;
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (cmd_i.rd_regs) begin
      rfa_q <= rf_mem[ra];
      rfb_q <= rf_mem[rt];
      va_q  <= rf_vld_q[ra];
      vb_q  <= rf_vld_q[rt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) dmem[mem_wa] <= mem_wd;
    if (cmd_i.agen) w_q <= dmem[slot_now];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.agen) begin
      ea_q   <= ea_now;
      prod_q <= {32'h0, a} * {32'h0, b};
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign div_t = {rem_q, quo_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= 6'd0;
    end else if (cmd_i.agen && cmd_q == CMD_EXEC && op == OP_SPECIAL &&
                 (fn == FN_DIV || fn == FN_DIVU) && b != 32'h0) begin
      div_cnt_q <= 6'd32;
    end else if (div_cnt_q != 6'd0) begin
      div_cnt_q <= div_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.agen) begin
      rem_q  <= 32'h0;
      if (fn == FN_DIV) begin
        quo_q  <= a[31] ? (32'h0 - a) : a;
        dvs_q  <= b[31] ? (32'h0 - b) : b;
        qneg_q <= a[31] ^ b[31];
        rneg_q <= a[31];
      end else begin
        quo_q  <= a;
        dvs_q  <= b;
        qneg_q <= 1'b0;
        rneg_q <= 1'b0;
      end
    end else if (div_cnt_q != 6'd0) begin
      if (div_t >= {1'b0, dvs_q}) begin
        rem_q <= 32'(div_t - {1'b0, dvs_q});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= div_t[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [31:0] s, tgt, sh32, lnk;
    logic [1:0]  k;
    logic [4:0]  u;
    rf_we  = 1'b0;
    rf_wa  = 5'd0;
    rf_wd  = 32'h0;
    mem_we = 1'b0;
    mem_wa = slot_ea;
    mem_wd = 32'h0;
    hi_we  = 1'b0;
    lo_we  = 1'b0;
    hi_wd  = 32'h0;
    lo_wd  = 32'h0;
    st     = ST_OK;
    rv     = 32'h0;
    pc_nx  = pc_q;
    npc_nx = npc_q;
    after  = npc_q + 32'd4;
    tgt    = pc_q + 32'd4 + {simm[29:0], 2'b00};
    lnk    = pc_q + 32'd8;
    k      = ea_q[1:0];
    u      = 5'd0;
    s      = 32'h0;
    sh32   = 32'h0;
    unique case (cmd_q)
      CMD_EXEC: begin
        unique case (op)
          OP_SPECIAL: begin
            unique case (fn)
              FN_SLL:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = b << sa; end
              FN_SRL:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = b >> sa; end
              FN_SRA:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = $signed(b) >>> sa; end
              FN_SLLV: begin rf_we = 1'b1; rf_wa = rd; rf_wd = b << a[4:0]; end
              FN_SRLV: begin rf_we = 1'b1; rf_wa = rd; rf_wd = b >> a[4:0]; end
              FN_SRAV: begin rf_we = 1'b1; rf_wa = rd; rf_wd = $signed(b) >>> a[4:0]; end
              FN_JR:   after = a;
              FN_JALR: begin rf_we = 1'b1; rf_wa = rd; rf_wd = lnk; after = a; end
              FN_MFHI: begin rf_we = 1'b1; rf_wa = rd; rf_wd = hi_q; end
              FN_MTHI: begin hi_we = 1'b1; hi_wd = a; end
              FN_MFLO: begin rf_we = 1'b1; rf_wa = rd; rf_wd = lo_q; end
              FN_MTLO: begin lo_we = 1'b1; lo_wd = a; end
              FN_MULT: begin
                hi_we = 1'b1; lo_we = 1'b1;
                lo_wd = prod_q[31:0];
                hi_wd = prod_q[63:32] - (a[31] ? b : 32'h0) - (b[31] ? a : 32'h0);
              end
              FN_MULTU: begin
                hi_we = 1'b1; lo_we = 1'b1;
                lo_wd = prod_q[31:0];
                hi_wd = prod_q[63:32];
              end
              FN_DIV, FN_DIVU: begin
                if (b != 32'h0) begin
                  hi_we = 1'b1; lo_we = 1'b1;
                  lo_wd = qneg_q ? (32'h0 - quo_q) : quo_q;
                  hi_wd = rneg_q ? (32'h0 - rem_q) : rem_q;
                end
              end
              FN_ADD: begin
                s = a + b;
                if (((a ^ s) & (b ^ s) & 32'h80000000) != 32'h0) st = ST_OVF;
                else begin rf_we = 1'b1; rf_wa = rd; rf_wd = s; end
              end
              FN_ADDU: begin rf_we = 1'b1; rf_wa = rd; rf_wd = a + b; end
              FN_SUB: begin
                s = a - b;
                if (((a ^ b) & (a ^ s) & 32'h80000000) != 32'h0) st = ST_OVF;
                else begin rf_we = 1'b1; rf_wa = rd; rf_wd = s; end
              end
              FN_SUBU: begin rf_we = 1'b1; rf_wa = rd; rf_wd = a - b; end
              FN_AND:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = a & b; end
              FN_OR:   begin rf_we = 1'b1; rf_wa = rd; rf_wd = a | b; end
              FN_XOR:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = a ^ b; end
              FN_NOR:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = ~(a | b); end
              FN_SLT: begin
                rf_we = 1'b1; rf_wa = rd; rf_wd = {31'h0, $signed(a) < $signed(b)};
              end
              FN_SLTU: begin rf_we = 1'b1; rf_wa = rd; rf_wd = {31'h0, a < b}; end
              default: ;
            endcase
          end
          OP_REGIMM: begin
            unique case (rt)
              RT_BLTZ: if (a[31]) after = tgt;
              RT_BGEZ: if (!a[31]) after = tgt;
              RT_BLTZAL: begin
                rf_we = 1'b1; rf_wa = LINK_REG; rf_wd = lnk;
                if (a[31]) after = tgt;
              end
              RT_BGEZAL: begin
                rf_we = 1'b1; rf_wa = LINK_REG; rf_wd = lnk;
                if (!a[31]) after = tgt;
              end
              default: ;
            endcase
          end
          OP_J: after = {npc_q[31:28], ins_q[25:0], 2'b00};
          OP_JAL: begin
            rf_we = 1'b1; rf_wa = LINK_REG; rf_wd = lnk;
            after = {npc_q[31:28], ins_q[25:0], 2'b00};
          end
          OP_BEQ:  if (a == b) after = tgt;
          OP_BNE:  if (a != b) after = tgt;
          OP_BLEZ: if (a[31] || a == 32'h0) after = tgt;
          OP_BGTZ: if (!a[31] && a != 32'h0) after = tgt;
          OP_ADDI: begin
            s = ea_q;
            if (((a ^ s) & (simm ^ s) & 32'h80000000) != 32'h0) st = ST_OVF;
            else begin rf_we = 1'b1; rf_wa = rt; rf_wd = s; end
          end
          OP_ADDIU: begin rf_we = 1'b1; rf_wa = rt; rf_wd = ea_q; end
          OP_SLTI: begin
            rf_we = 1'b1; rf_wa = rt; rf_wd = {31'h0, $signed(a) < $signed(simm)};
          end
          OP_SLTIU: begin rf_we = 1'b1; rf_wa = rt; rf_wd = {31'h0, a < simm}; end
          OP_ANDI: begin rf_we = 1'b1; rf_wa = rt; rf_wd = a & imm; end
          OP_ORI:  begin rf_we = 1'b1; rf_wa = rt; rf_wd = a | imm; end
          OP_XORI: begin rf_we = 1'b1; rf_wa = rt; rf_wd = a ^ imm; end
          OP_LUI:  begin rf_we = 1'b1; rf_wa = rt; rf_wd = {ins_q[15:0], 16'h0000}; end
          OP_LB, OP_LBU: begin
            u = {~k, 3'b000};
            s = w_q >> u;
            rf_we = 1'b1; rf_wa = rt;
            rf_wd = (op == OP_LB) ? {{24{s[7]}}, s[7:0]} : {24'h0, s[7:0]};
          end
          OP_LH, OP_LHU: begin
            if (ea_q[0]) st = ST_MIS;
            else begin
              u = k[1] ? 5'd0 : 5'd16;
              s = w_q >> u;
              rf_we = 1'b1; rf_wa = rt;
              rf_wd = (op == OP_LH) ? {{16{s[15]}}, s[15:0]} : {16'h0, s[15:0]};
            end
          end
          OP_LW: begin
            if (k != 2'd0) st = ST_MIS;
            else begin rf_we = 1'b1; rf_wa = rt; rf_wd = w_q; end
          end
          OP_LWL: begin
            u = {k, 3'b000};
            sh32 = ~(32'hFFFFFFFF << u);
            rf_we = 1'b1; rf_wa = rt; rf_wd = (w_q << u) | (b & sh32);
          end
          OP_LWR: begin
            u = {~k, 3'b000};
            sh32 = 32'hFFFFFFFF >> u;
            rf_we = 1'b1; rf_wa = rt; rf_wd = (w_q >> u) | (b & ~sh32);
          end
          OP_SB: begin
            u = {~k, 3'b000};
            mem_we = 1'b1;
            mem_wd = (w_q & ~(32'h000000FF << u)) | ({24'h0, b[7:0]} << u);
          end
          OP_SH: begin
            if (ea_q[0]) st = ST_MIS;
            else begin
              u = k[1] ? 5'd0 : 5'd16;
              mem_we = 1'b1;
              mem_wd = (w_q & ~(32'h0000FFFF << u)) | ({16'h0, b[15:0]} << u);
            end
          end
          OP_SW: begin
            if (k != 2'd0) st = ST_MIS;
            else begin mem_we = 1'b1; mem_wd = b; end
          end
          OP_SWL: begin
            u = {k, 3'b000};
            mem_we = 1'b1;
            mem_wd = (b >> u) | (w_q & ~(32'hFFFFFFFF >> u));
          end
          OP_SWR: begin
            u = {~k, 3'b000};
            mem_we = 1'b1;
            mem_wd = (b << u) | (w_q & ~(32'hFFFFFFFF << u));
          end
          default: ;
        endcase
        pc_nx  = npc_q;
        npc_nx = after;
      end
      CMD_PRELOAD: begin
        mem_we = 1'b1; mem_wa = addr_q[AW+1:2]; mem_wd = data_q;
      end
      CMD_WRREG: begin rf_we = 1'b1; rf_wa = ri_q; rf_wd = data_q; end
      CMD_SETPC: begin pc_nx = addr_q; npc_nx = addr_q + 32'd4; end
      CMD_RDREG: rv = a;
      default: ;
    endcase
    if (rf_wa == 5'd0) rf_we = 1'b0;
    if (!cmd_i.commit) begin
      rf_we  = 1'b0;
      mem_we = 1'b0;
      hi_we  = 1'b0;
      lo_we  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 32'h0;
      npc_q       <= 32'd4;
      hi_q        <= 32'h0;
      lo_q        <= 32'h0;
      rf_vld_q    <= 32'h0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        pc_q  <= pc_nx;
        npc_q <= npc_nx;
      end
      if (hi_we) hi_q <= hi_wd;
      if (lo_we) lo_q <= lo_wd;
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pc_o            <= pc_nx;
      status_o        <= st;
      reg_written_o   <= rf_we;
      written_index_o <= rf_we ? rf_wa : 5'd0;
      written_value_o <= rf_we ? rf_wd : 32'h0;
      read_value_o    <= rv;
    end
  end
endmodule
`default_nettype wire

@@ hdl/mips_integer_core_execute.sv @@
// Each item is latched, then passes the register read, address and
// product, and execute states; execute waits for the divider and output.
// One item at a time: a new input is taken only back in idle.
// Reset clears pc to 0, next pc to 4, HI, LO and all registers to zero;
// the data memory holds no reset value.
`default_nettype none
module mips_integer_core_execute #(
  parameter int unsigned DataWords = mice_pkg::DataWordsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] address_i,
  input  wire logic [4:0]  reg_index_i,
  input  wire logic [31:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pc_o,
  output logic [1:0]       status_o,
  output logic             reg_written_o,
  output logic [4:0]       written_index_o,
  output logic [31:0]      written_value_o,
  output logic [31:0]      read_value_o
);
  import mice_pkg::*;

  mice_cmd_t cmd;
  mice_sts_t sts;

  mice_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mice_dpath #(.DataWords(DataWords)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .instruction_i   (instruction_i),
    .address_i       (address_i),
    .reg_index_i     (reg_index_i),
    .data_i          (data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pc_o            (pc_o),
    .status_o        (status_o),
    .reg_written_o   (reg_written_o),
    .written_index_o (written_index_o),
    .written_value_o (written_value_o),
    .read_value_o    (read_value_o)
  );
endmodule
`default_nettype wire

@@ verif/mips_integer_core_execute_tb.sv @@
`default_nettype none
module mips_integer_core_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mice_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MemWords   = 16;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] ins;
    logic [31:0] addr;
    logic [4:0]  ri;
    logic [31:0] data;
  } cpu_req_t;

  typedef struct {
    logic [31:0] pc;
    logic [1:0]  st;
    logic        wr;
    logic [4:0]  wi;
    logic [31:0] wv;
    logic [31:0] rv;
  } cpu_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CMD_EXEC;
  logic [31:0] instruction = '0;
  logic [31:0] address = '0;
  logic [4:0]  reg_index = '0;
  logic [31:0] data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pc;
  logic [1:0]  status;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic [31:0] read_value;

  mips_integer_core_execute u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .instruction_i  (instruction),
    .address_i      (address),
    .reg_index_i    (reg_index),
    .data_i         (data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pc_o           (pc),
    .status_o       (status),
    .reg_written_o  (reg_written),
    .written_index_o(written_index),
    .written_value_o(written_value),
    .read_value_o   (read_value)
  );

  cpu_req_t    pending_q[$];
  cpu_rsp_t    rsp_q[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;
  int unsigned cycles = 0;
  int unsigned fails = 0;

  // architectural state
  logic [31:0] arch_pc = 32'd0;
  logic [31:0] arch_npc = 32'd4;
  logic [31:0] gpr [32];
  logic [31:0] hi_q = '0;
  logic [31:0] lo_q = '0;
  logic [31:0] dmem [int unsigned];
  logic        wr_f;
  logic [4:0]  wr_i;
  logic [31:0] wr_v;

  initial foreach (gpr[i]) gpr[i] = '0;

  initial forever #1 clk_i = ~clk_i;

  function automatic void set_gpr(logic [4:0] idx, logic [31:0] v);
    if (idx != 5'd0) begin
      gpr[idx] = v;
      wr_f = 1'b1;
      wr_i = idx;
      wr_v = v;
    end
  endfunction

  function automatic logic [31:0] mem_rd(int unsigned slot);
    return dmem.exists(slot) ? dmem[slot] : 32'd0;
  endfunction

  function automatic logic [1:0] run_insn(logic [31:0] ins);
    logic [5:0]  op;
    logic [4:0]  rs, rt, rd, sa;
    logic [5:0]  fn;
    logic [31:0] imm, simm, a, b, cur, target, after, s, ea, w, ua, ub, q, r;
    logic [1:0]  st;
    logic [1:0]  k;
    int unsigned slot, u;
    logic [63:0] p;
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sa = ins[10:6]; fn = ins[5:0];
    imm = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = gpr[rs]; b = gpr[rt];
    cur = arch_pc;
    target = cur + 32'd4 + (simm << 2);
    after = arch_npc + 32'd4;
    st = ST_OK;
    ea = a + simm;
    k = ea[1:0];
    slot = (ea >> 2) % DataWordsDefault;
    w = mem_rd(slot);
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  set_gpr(rd, b << sa);
          FN_SRL:  set_gpr(rd, b >> sa);
          FN_SRA:  set_gpr(rd, $signed(b) >>> sa);
          FN_SLLV: set_gpr(rd, b << a[4:0]);
          FN_SRLV: set_gpr(rd, b >> a[4:0]);
          FN_SRAV: set_gpr(rd, $signed(b) >>> a[4:0]);
          FN_JR:   after = a;
          FN_JALR: begin set_gpr(rd, cur + 32'd8); after = a; end
          FN_MFHI: set_gpr(rd, hi_q);
          FN_MTHI: hi_q = a;
          FN_MFLO: set_gpr(rd, lo_q);
          FN_MTLO: lo_q = a;
          FN_MULT: begin
            p = 64'($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
            {hi_q, lo_q} = p;
          end
          FN_MULTU: begin
            p = {32'd0, a} * {32'd0, b};
            {hi_q, lo_q} = p;
          end
          FN_DIV: if (b != 0) begin
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            r = ua % ub;
            if (a[31] ^ b[31]) q = -q;
            if (a[31]) r = -r;
            lo_q = q;
            hi_q = r;
          end
          FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
          FN_ADD: begin
            s = a + b;
            if (((a ^ s) & (b ^ s) & 32'h8000_0000) != 0) st = ST_OVF;
            else set_gpr(rd, s);
          end
          FN_ADDU: set_gpr(rd, a + b);
          FN_SUB: begin
            s = a - b;
            if (((a ^ b) & (a ^ s) & 32'h8000_0000) != 0) st = ST_OVF;
            else set_gpr(rd, s);
          end
          FN_SUBU: set_gpr(rd, a - b);
          FN_AND:  set_gpr(rd, a & b);
          FN_OR:   set_gpr(rd, a | b);
          FN_XOR:  set_gpr(rd, a ^ b);
          FN_NOR:  set_gpr(rd, ~(a | b));
          FN_SLT:  set_gpr(rd, {31'd0, $signed(a) < $signed(b)});
          FN_SLTU: set_gpr(rd, {31'd0, a < b});
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZ) begin if (a[31]) after = target; end
        else if (rt == RT_BGEZ) begin if (!a[31]) after = target; end
        else if (rt == RT_BLTZAL) begin
          set_gpr(LINK_REG, cur + 32'd8);
          if (a[31]) after = target;
        end else if (rt == RT_BGEZAL) begin
          set_gpr(LINK_REG, cur + 32'd8);
          if (!a[31]) after = target;
        end
      end
      OP_J:   after = (arch_npc & 32'hF000_0000) | ({6'd0, ins[25:0]} << 2);
      OP_JAL: begin
        set_gpr(LINK_REG, cur + 32'd8);
        after = (arch_npc & 32'hF000_0000) | ({6'd0, ins[25:0]} << 2);
      end
      OP_BEQ:  if (a == b) after = target;
      OP_BNE:  if (a != b) after = target;
      OP_BLEZ: if (a[31] || a == 0) after = target;
      OP_BGTZ: if (!a[31] && a != 0) after = target;
      OP_ADDI: begin
        s = a + simm;
        if (((a ^ s) & (simm ^ s) & 32'h8000_0000) != 0) st = ST_OVF;
        else set_gpr(rt, s);
      end
      OP_ADDIU: set_gpr(rt, a + simm);
      OP_SLTI:  set_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
      OP_SLTIU: set_gpr(rt, {31'd0, a < simm});
      OP_ANDI:  set_gpr(rt, a & imm);
      OP_ORI:   set_gpr(rt, a | imm);
      OP_XORI:  set_gpr(rt, a ^ imm);
      OP_LUI:   set_gpr(rt, imm << 16);
      OP_LB: begin
        s = w >> (8 * (3 - k));
        set_gpr(rt, {{24{s[7]}}, s[7:0]});
      end
      OP_LBU: set_gpr(rt, (w >> (8 * (3 - k))) & 32'hFF);
      OP_LH: begin
        if (ea[0]) st = ST_MIS;
        else begin
          s = w >> (8 * (2 - k));
          set_gpr(rt, {{16{s[15]}}, s[15:0]});
        end
      end
      OP_LHU: begin
        if (ea[0]) st = ST_MIS;
        else set_gpr(rt, (w >> (8 * (2 - k))) & 32'hFFFF);
      end
      OP_LW: if (k != 0) st = ST_MIS; else set_gpr(rt, w);
      OP_LWL: begin
        u = 8 * k;
        set_gpr(rt, (w << u) | (b & ((32'd1 << u) - 32'd1)));
      end
      OP_LWR: begin
        u = 8 * (3 - k);
        set_gpr(rt, (w >> u) | (b & ~(32'hFFFF_FFFF >> u)));
      end
      OP_SB: begin
        u = 8 * (3 - k);
        dmem[slot] = (w & ~(32'hFF << u)) | ((b & 32'hFF) << u);
      end
      OP_SH: begin
        if (ea[0]) st = ST_MIS;
        else begin
          u = 8 * (2 - k);
          dmem[slot] = (w & ~(32'hFFFF << u)) | ((b & 32'hFFFF) << u);
        end
      end
      OP_SW: if (k != 0) st = ST_MIS; else dmem[slot] = b;
      OP_SWL: begin
        u = 8 * k;
        dmem[slot] = (b >> u) | (w & ~(32'hFFFF_FFFF >> u));
      end
      OP_SWR: begin
        u = 8 * (3 - k);
        dmem[slot] = (b << u) | (w & ((32'd1 << u) - 32'd1));
      end
      default: ;
    endcase
    arch_pc = arch_npc;
    arch_npc = after;
    gpr[0] = '0;
    return st;
  endfunction

  function automatic cpu_rsp_t predict_core(cpu_req_t t);
    cpu_rsp_t o;
    wr_f = 1'b0; wr_i = '0; wr_v = '0;
    o.st = ST_OK;
    o.rv = '0;
    case (t.cmd)
      CMD_EXEC:    o.st = run_insn(t.ins);
      CMD_PRELOAD: dmem[(t.addr >> 2) % DataWordsDefault] = t.data;
      CMD_WRREG:   set_gpr(t.ri, t.data);
      CMD_SETPC:   begin arch_pc = t.addr; arch_npc = t.addr + 32'd4; end
      CMD_RDREG:   o.rv = gpr[t.ri];
      default: ;
    endcase
    o.pc = arch_pc;
    o.wr = wr_f;
    o.wi = wr_i;
    o.wv = wr_v;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cpu_req_t t;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        t.cmd = command; t.ins = instruction; t.addr = address;
        t.ri = reg_index; t.data = data;
        rsp_q.push_back(predict_core(t));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          t = pending_q.pop_front();
          command <= t.cmd;
          instruction <= t.ins;
          address <= t.addr;
          reg_index <= t.ri;
          data <= t.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      $error("%s: expected %h, got %h", name, e, g);
      fails++;
    end
  endfunction

  // monitor and receiver stall
  always @(posedge clk_i) begin
    cpu_rsp_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end else if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          $error("transfer with no result expected");
          fails++;
        end else begin
          e = rsp_q.pop_front();
          cmp_field("pc", e.pc, pc);
          cmp_field("status", 32'(e.st), 32'(status));
          cmp_field("reg_written", 32'(e.wr), 32'(reg_written));
          cmp_field("written_index", 32'(e.wi), 32'(written_index));
          cmp_field("written_value", e.wv, written_value);
          cmp_field("read_value", e.rv, read_value);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic cpu_req_t mk_req(logic [2:0] c, logic [31:0] i, logic [31:0] ad,
                                      logic [4:0] r, logic [31:0] d);
    cpu_req_t t;
    t.cmd = c; t.ins = i; t.addr = ad; t.ri = r; t.data = d;
    return t;
  endfunction

  function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] odd_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit is_mem(logic [5:0] op);
    return op inside {OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
                      OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR};
  endfunction

  // base register load, then the access; stays inside the preloaded words
  task automatic push_mem(logic [5:0] op);
    logic [4:0]  rb;
    logic [31:0] base;
    int          ofs;
    rb = 5'($urandom_range(31, 1));
    base = ($urandom & 32'hFFFF_C000) + $urandom_range(2 * MemWords - 1, MemWords);
    ofs = $urandom_range(2 * MemWords - 1) - MemWords;
    pending_q.push_back(mk_req(CMD_WRREG, $urandom, $urandom, rb, base));
    pending_q.push_back(mk_req(CMD_EXEC, i_type(op, rb, 5'($urandom), 16'(ofs)),
                               $urandom, 5'($urandom), $urandom));
  endtask

  task automatic push_random();
    logic [5:0] mem_ops[12];
    logic [5:0] fns[26];
    logic [31:0] ins;
    int unsigned pick;
    mem_ops = '{OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
                OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR};
    fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
            FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
            FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
            FN_SLT, FN_SLTU};
    pick = $urandom_range(99);
    if (pick < 30) begin
      ins = $urandom;
      if (is_mem(ins[31:26])) push_mem(ins[31:26]);
      else pending_q.push_back(mk_req(CMD_EXEC, ins, $urandom, 5'($urandom), $urandom));
    end else if (pick < 55) begin
      ins = $urandom;
      ins[31:26] = OP_SPECIAL;
      ins[5:0] = fns[$urandom_range(25)];
      pending_q.push_back(mk_req(CMD_EXEC, ins, $urandom, 5'($urandom), $urandom));
    end else if (pick < 65) begin
      ins = $urandom;
      ins[31:26] = 6'($urandom_range(7, 1));
      if (ins[31:26] == OP_REGIMM && $urandom_range(3) != 0)
        ins[20:16] = ins[16] ? ($urandom_range(1) ? RT_BGEZ : RT_BGEZAL)
                             : ($urandom_range(1) ? RT_BLTZ : RT_BLTZAL);
      pending_q.push_back(mk_req(CMD_EXEC, ins, $urandom, 5'($urandom), $urandom));
    end else if (pick < 80) begin
      push_mem(mem_ops[$urandom_range(11)]);
    end else if (pick < 88) begin
      pending_q.push_back(mk_req(CMD_WRREG, $urandom, $urandom, 5'($urandom), odd_word()));
    end else if (pick < 92) begin
      pending_q.push_back(mk_req(CMD_RDREG, $urandom, $urandom, 5'($urandom), $urandom));
    end else if (pick < 95) begin
      pending_q.push_back(mk_req(CMD_SETPC, $urandom, odd_word(), 5'($urandom), $urandom));
    end else if (pick < 97) begin
      pending_q.push_back(mk_req(CMD_PRELOAD, $urandom, $urandom, 5'($urandom), $urandom));
    end else begin
      pending_q.push_back(mk_req(3'($urandom_range(7, 5)), $urandom, $urandom,
                                 5'($urandom), $urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || rsp_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < MemWords; i++)
      pending_q.push_back(mk_req(CMD_PRELOAD, '0, 32'(4 * i) | 32'($urandom_range(3)),
                                 '0, $urandom));
    pending_q.push_back(mk_req(CMD_WRREG, '0, '0, 5'd1, 32'h7FFF_FFFF));
    pending_q.push_back(mk_req(CMD_WRREG, '0, '0, 5'd2, 32'h0000_0001));
    pending_q.push_back(mk_req(CMD_WRREG, '0, '0, 5'd3, 32'h8000_0000));
    pending_q.push_back(mk_req(CMD_WRREG, '0, '0, 5'd4, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(CMD_WRREG, '0, '0, 5'd0, 32'hFFFF_FFFF));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd1, 5'd2, 5'd5, 5'd0, FN_ADD), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd3, 5'd2, 5'd5, 5'd0, FN_SUB), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, i_type(OP_ADDI, 5'd1, 5'd6, 16'd1), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd3, 5'd4, 5'd0, 5'd0, FN_DIV), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd0, 5'd0, 5'd7, 5'd0, FN_MFLO), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd0, 5'd0, 5'd8, 5'd0, FN_MFHI), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd4, 5'd4, 5'd9, 5'd0, FN_MULT), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd4, 5'd4, 5'd9, 5'd0, FN_MULTU), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd0, 5'd1, 5'd0, 5'd3, FN_SLL), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, i_type(OP_LW, 5'd2, 5'd10, 16'd0), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, i_type(6'd63, 5'd1, 5'd2, 16'hFFFF), '0, '0, '0));
    pending_q.push_back(mk_req(CMD_EXEC, r_type(5'd1, 5'd0, 5'd31, 5'd0, FN_JALR), '0, '0,
                               '0));
    pending_q.push_back(mk_req(CMD_EXEC, i_type(OP_REGIMM, 5'd3, RT_BLTZ, 16'h8000), '0, '0,
                               '0));
    pending_q.push_back(mk_req(CMD_SETPC, '0, 32'hFFFF_FFFC, '0, '0));
    pending_q.push_back(mk_req(CMD_RDREG, '0, '0, 5'd31, '0));
    pending_q.push_back(mk_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 8 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 8 : 0;
      if (ph == 2) hold_req++;
      for (int n = 0; n < 420; n++) push_random();
      wait_drained();
    end

    repeat (60) @(posedge clk_i);
    if (fails == 0 && rsp_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ mips_integer_core_execute.f @@
hdl/mice_pkg.sv
hdl/mice_ctrl.sv
hdl/mice_dpath.sv
hdl/mips_integer_core_execute.sv
verif/mips_integer_core_execute_tb.sv
